FILE: design/tmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmm_pkg;

    // One input item: an A element, the B element at the same position and the final-block flag
    typedef struct packed {
        logic signed [31:0] a_value;
        logic signed [31:0] b_value;
        logic               final_block;
    } operand_t;

    // One result item: a C element and the end-of-tile mark
    typedef struct packed {
        logic signed [31:0] c_value;
        logic               last;
    } result_t;

    // Controls one MAC issue slot
    typedef struct packed {
        logic valid;
        logic first_k;
        logic last_k;
    } issue_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_DRAIN,
        ST_EMIT
    } tmm_state_t;

endpackage : tmm_pkg

`default_nettype wire

FILE: design/tiled_matrix_multiply_accumulate_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Tiled matrix multiply-accumulate.
// Input channel: an item (operands) is taken at a rising edge with start high and
// busy low. Each item carries one A element and the B element at the same
// row-major position of a TILE x TILE tile; items fill both tiles in order.
// Items that do not complete a tile give no result and leave the block ready
// for the next item. On the item that completes a tile the block goes busy and
// runs TILE^3 MACs through one multiplier fed by one read port on each operand
// memory, then waits until the MAC pipeline has drained; busy also stays high
// through the read-out when the tile emits. If final_block is high on that
// completing item, the C tile is then read out of the accumulator memory, one
// element a cycle: TILE*TILE results in row-major order, the first one after
// the drain state and a registered read of the accumulator memory, the last
// one marked by result.last. Each emitted entry is cleared as it is read.
// Result channel: each result sits on result for one cycle under result_strobe;
// the receiver cannot stall and must take it then.
// Reset clears the pair count, the state machine and the accumulator valid
// bits, so C reads as zero at once; no clearing pass is needed.
module tiled_matrix_multiply_accumulate_top
    import tmm_pkg::*;
#(
    parameter int TILE = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire operand_t operands,
    output result_t       result,
    output logic          result_strobe
);

    localparam int AREA_W = $clog2(TILE * TILE);

    logic              st_wr_en;
    logic [AREA_W-1:0] st_wr_addr;
    logic [AREA_W-1:0] a_rd_addr;
    logic [AREA_W-1:0] b_rd_addr;
    logic [31:0]       a_q;
    logic [31:0]       b_q;
    issue_ctl_t        issue;
    logic [AREA_W-1:0] issue_c_addr;
    logic              emit_rd_en;
    logic [AREA_W-1:0] emit_addr;
    logic              mac_rd_en;
    logic [AREA_W-1:0] mac_rd_addr;
    logic              c_rd_en;
    logic [AREA_W-1:0] c_rd_addr;
    logic              c_wr_en;
    logic [AREA_W-1:0] c_wr_addr;
    logic [31:0]       c_wr_data;
    logic [31:0]       c_q;
    logic              pipe_busy;
    logic              res_last;

    // Sequence loading, MAC issue, drain and read-out
    tmm_ctrl #(
        .TILE (TILE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .final_block  (operands.final_block),
        .pipe_busy    (pipe_busy),
        .busy         (busy),
        .st_wr_en     (st_wr_en),
        .st_wr_addr   (st_wr_addr),
        .a_rd_addr    (a_rd_addr),
        .b_rd_addr    (b_rd_addr),
        .issue        (issue),
        .issue_c_addr (issue_c_addr),
        .emit_rd_en   (emit_rd_en),
        .emit_addr    (emit_addr),
        .strobe       (result_strobe),
        .last         (res_last)
    );

    // A and B tile memories: written by arriving items, read by the MAC
    tmm_operand_store #(
        .TILE (TILE)
    ) u_operands (
        .clk       (clk),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_a      (operands.a_value),
        .wr_b      (operands.b_value),
        .rd_en     (issue.valid),
        .rd_addr_a (a_rd_addr),
        .rd_addr_b (b_rd_addr),
        .rd_a      (a_q),
        .rd_b      (b_q)
    );

    // Multiply, sum over k, then read-modify-write the C entry
    tmm_mac #(
        .TILE (TILE)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .issue_c_addr (issue_c_addr),
        .a_q          (a_q),
        .b_q          (b_q),
        .c_q          (c_q),
        .c_rd_en      (mac_rd_en),
        .c_rd_addr    (mac_rd_addr),
        .c_wr_en      (c_wr_en),
        .c_wr_addr    (c_wr_addr),
        .c_wr_data    (c_wr_data),
        .pipe_busy    (pipe_busy)
    );

    // The MAC and the read-out never overlap: share the single C read port
    assign c_rd_en   = mac_rd_en || emit_rd_en;
    assign c_rd_addr = emit_rd_en ? emit_addr : mac_rd_addr;

    tmm_accum_store #(
        .TILE (TILE)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (c_rd_en),
        .rd_addr (c_rd_addr),
        .clr_en  (emit_rd_en),
        .wr_en   (c_wr_en),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_data (c_q)
    );

    assign result.c_value = c_q;
    assign result.last    = res_last;

endmodule : tiled_matrix_multiply_accumulate_top

`default_nettype wire

FILE: design/tmm_operand_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tmm_operand_store
    import tmm_pkg::*;
#(
    parameter int TILE = 8
) (
    input  wire logic                                clk,
    input  wire logic                                wr_en,
    input  wire logic [$clog2(TILE*TILE)-1:0]        wr_addr,
    input  wire logic [31:0]                         wr_a,
    input  wire logic [31:0]                         wr_b,
    input  wire logic                                rd_en,
    input  wire logic [$clog2(TILE*TILE)-1:0]        rd_addr_a,
    input  wire logic [$clog2(TILE*TILE)-1:0]        rd_addr_b,
    output logic [31:0]                              rd_a,
    output logic [31:0]                              rd_b
);

    localparam int AREA = TILE * TILE;

    logic [31:0] a_mem [AREA];
    logic [31:0] b_mem [AREA];
    logic [31:0] a_q_reg;
    logic [31:0] b_q_reg;

    // Write the arriving pair, read both operands of the next MAC
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            a_mem[wr_addr] <= wr_a;
            b_mem[wr_addr] <= wr_b;
        end
        if (rd_en)
        begin
            a_q_reg <= a_mem[rd_addr_a];
            b_q_reg <= b_mem[rd_addr_b];
        end
    end

    assign rd_a = a_q_reg;
    assign rd_b = b_q_reg;

endmodule : tmm_operand_store

`default_nettype wire

FILE: design/tmm_accum_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tmm_accum_store
    import tmm_pkg::*;
#(
    parameter int TILE = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                rd_en,
    input  wire logic [$clog2(TILE*TILE)-1:0]        rd_addr,
    input  wire logic                                clr_en,
    input  wire logic                                wr_en,
    input  wire logic [$clog2(TILE*TILE)-1:0]        wr_addr,
    input  wire logic [31:0]                         wr_data,
    output logic [31:0]                              rd_data
);

    localparam int AREA = TILE * TILE;

    logic [31:0]     c_mem [AREA];
    logic [31:0]     c_q_reg;
    logic [AREA-1:0] valid_reg;
    logic [AREA-1:0] valid_next;
    logic            hit_reg;
    logic            hit_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            c_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            c_q_reg <= c_mem[rd_addr];
        end
    end

    // An entry never written since reset or since it was emitted reads as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (clr_en)
        begin
            valid_next[rd_addr] = 1'b0;
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        hit_next = rd_en ? valid_reg[rd_addr] : hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign rd_data = hit_reg ? c_q_reg : '0;

endmodule : tmm_accum_store

`default_nettype wire

FILE: design/tmm_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module tmm_mac
    import tmm_pkg::*;
#(
    parameter int TILE = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire issue_ctl_t                          issue,
    input  wire logic [$clog2(TILE*TILE)-1:0]        issue_c_addr,
    input  wire logic [31:0]                         a_q,
    input  wire logic [31:0]                         b_q,
    input  wire logic [31:0]                         c_q,
    output logic                                     c_rd_en,
    output logic [$clog2(TILE*TILE)-1:0]             c_rd_addr,
    output logic                                     c_wr_en,
    output logic [$clog2(TILE*TILE)-1:0]             c_wr_addr,
    output logic [31:0]                              c_wr_data,
    output logic                                     pipe_busy
);

    localparam int AREA_W = $clog2(TILE * TILE);

    issue_ctl_t          s1_ctl_reg;
    issue_ctl_t          s2_ctl_reg;
    logic [AREA_W-1:0]   s1_addr_reg;
    logic [AREA_W-1:0]   s2_addr_reg;
    logic [AREA_W-1:0]   s3_addr_reg;
    logic                s3_valid_reg;
    logic [31:0]         prod_reg;
    logic [31:0]         prod_next;
    logic [31:0]         sum_reg;
    logic [31:0]         sum_next;
    logic [31:0]         s3_sum_reg;

    // Low 32 bits of the product are the same for signed and unsigned operands
    assign prod_next = a_q * b_q;

    always_comb
    begin
        sum_next = (s2_ctl_reg.first_k ? 32'd0 : sum_reg) + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg   <= '0;
            s2_ctl_reg   <= '0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_ctl_reg   <= issue;
            s2_ctl_reg   <= s1_ctl_reg;
            s3_valid_reg <= s2_ctl_reg.valid && s2_ctl_reg.last_k;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= issue_c_addr;
        s2_addr_reg <= s1_addr_reg;
        s3_addr_reg <= s2_addr_reg;
        if (s1_ctl_reg.valid)
        begin
            prod_reg <= prod_next;
        end
        if (s2_ctl_reg.valid)
        begin
            sum_reg    <= sum_next;
            s3_sum_reg <= sum_next;
        end
    end

    // Fetch the old C entry as the dot product completes, add it back next cycle
    assign c_rd_en   = s2_ctl_reg.valid && s2_ctl_reg.last_k;
    assign c_rd_addr = s2_addr_reg;
    assign c_wr_en   = s3_valid_reg;
    assign c_wr_addr = s3_addr_reg;
    assign c_wr_data = c_q + s3_sum_reg;
    assign pipe_busy = s1_ctl_reg.valid || s2_ctl_reg.valid || s3_valid_reg;

endmodule : tmm_mac

`default_nettype wire

FILE: design/tmm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tmm_ctrl
    import tmm_pkg::*;
#(
    parameter int TILE = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                final_block,
    input  wire logic                                pipe_busy,
    output logic                                     busy,
    output logic                                     st_wr_en,
    output logic [$clog2(TILE*TILE)-1:0]             st_wr_addr,
    output logic [$clog2(TILE*TILE)-1:0]             a_rd_addr,
    output logic [$clog2(TILE*TILE)-1:0]             b_rd_addr,
    output issue_ctl_t                               issue,
    output logic [$clog2(TILE*TILE)-1:0]             issue_c_addr,
    output logic                                     emit_rd_en,
    output logic [$clog2(TILE*TILE)-1:0]             emit_addr,
    output logic                                     strobe,
    output logic                                     last
);

    localparam int AREA   = TILE * TILE;
    localparam int AREA_W = $clog2(AREA);
    localparam int IDX_W  = $clog2(TILE);
    localparam logic [AREA_W-1:0] TILE_A   = AREA_W'(TILE);
    localparam logic [AREA_W-1:0] AREA_END = AREA_W'(AREA - 1);
    localparam logic [IDX_W-1:0]  IDX_END  = IDX_W'(TILE - 1);

    tmm_state_t        state_reg;
    tmm_state_t        state_next;
    logic [AREA_W-1:0] pair_count_reg;
    logic [AREA_W-1:0] pair_count_next;
    logic [IDX_W-1:0]  r_reg;
    logic [IDX_W-1:0]  r_next;
    logic [IDX_W-1:0]  c_reg;
    logic [IDX_W-1:0]  c_next;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  k_next;
    logic [AREA_W-1:0] emit_reg;
    logic [AREA_W-1:0] emit_next;
    logic              final_reg;
    logic              final_next;
    logic              strobe_reg;
    logic              strobe_next;
    logic              last_reg;
    logic              last_next;
    logic              accept;
    logic              tile_full;
    logic              calc_end;
    logic              emit_end;

    assign accept    = start && (state_reg == ST_LOAD);
    assign tile_full = accept && (pair_count_reg == AREA_END);
    assign calc_end  = (r_reg == IDX_END) && (c_reg == IDX_END) && (k_reg == IDX_END);
    assign emit_end  = (emit_reg == AREA_END);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (tile_full)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (calc_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = final_reg ? ST_EMIT : ST_LOAD;
                end
            end
            ST_EMIT:
            begin
                if (emit_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Counters and flags
    always_comb
    begin
        pair_count_next = pair_count_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        emit_next       = emit_reg;
        final_next      = final_reg;
        if (accept)
        begin
            pair_count_next = tile_full ? '0 : pair_count_reg + 1'b1;
            final_next      = final_block;
            r_next          = '0;
            c_next          = '0;
            k_next          = '0;
            emit_next       = '0;
        end
        if (state_reg == ST_CALC)
        begin
            k_next = (k_reg == IDX_END) ? '0 : k_reg + 1'b1;
            if (k_reg == IDX_END)
            begin
                c_next = (c_reg == IDX_END) ? '0 : c_reg + 1'b1;
                if (c_reg == IDX_END)
                begin
                    r_next = (r_reg == IDX_END) ? '0 : r_reg + 1'b1;
                end
            end
        end
        if (state_reg == ST_EMIT)
        begin
            emit_next = emit_end ? '0 : emit_reg + 1'b1;
        end
    end

    // Outputs
    always_comb
    begin
        busy          = (state_reg != ST_LOAD);
        st_wr_en      = accept;
        st_wr_addr    = pair_count_reg;
        a_rd_addr     = AREA_W'(r_reg) * TILE_A + AREA_W'(k_reg);
        b_rd_addr     = AREA_W'(k_reg) * TILE_A + AREA_W'(c_reg);
        issue_c_addr  = AREA_W'(r_reg) * TILE_A + AREA_W'(c_reg);
        issue.valid   = (state_reg == ST_CALC);
        issue.first_k = (k_reg == '0);
        issue.last_k  = (k_reg == IDX_END);
        emit_rd_en    = (state_reg == ST_EMIT);
        emit_addr     = emit_reg;
        strobe_next   = (state_reg == ST_EMIT);
        last_next     = (state_reg == ST_EMIT) && emit_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            pair_count_reg <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            emit_reg       <= '0;
            final_reg      <= 1'b0;
            strobe_reg     <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pair_count_reg <= pair_count_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            k_reg          <= k_next;
            emit_reg       <= emit_next;
            final_reg      <= final_next;
            strobe_reg     <= strobe_next;
            last_reg       <= last_next;
        end
    end

    assign strobe = strobe_reg;
    assign last   = last_reg;

    // A result only follows a C read issued while emitting
    a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_EMIT))
        else $error("result strobe without an emit read");

    // The end-of-tile mark rides only on a strobed result
    a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> strobe_reg)
        else $error("last raised without strobe");

    // Emitting starts only once every accumulator write has landed
    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !pipe_busy)
        else $error("emit overlaps the MAC pipeline");

    // A new tile starts computing from the first element
    a_calc_from_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_CALC) |-> (r_reg == '0 && c_reg == '0 && k_reg == '0))
        else $error("tile computation started off origin");

endmodule : tmm_ctrl

`default_nettype wire

FILE: sim/tmm_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the tiled multiply-accumulate block. Keeps its own
// copy of the operand tiles and the accumulator, and queues the C tile that
// each final item should produce.
module tmm_checker
    import tmm_pkg::*;
#(
    parameter int TILE = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  operand_t operands,
    input  result_t  result,
    input  logic     result_strobe,
    output int       fail_count,
    output int       expected_left,
    output int       items_taken,
    output int       results_taken
);

    localparam int AREA = TILE * TILE;

    logic [31:0] a_tile [AREA];
    logic [31:0] b_tile [AREA];
    logic [31:0] c_sum  [AREA];
    int          fill_pos;
    result_t     c_tile_due [$];
    result_t     want;

    task automatic log_mismatch(input string field, input logic [31:0] exp_val,
                                input logic [31:0] got_val);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on C result %0d, %s: expected %0d, got %0d",
                     results_taken, field, $signed(exp_val), $signed(got_val));
    endtask

    // Add A*B into the accumulator, wrapping at 32 bits
    task automatic fold_tile_product();
        logic [31:0] dot;
        for (int r = 0; r < TILE; r++)
            for (int c = 0; c < TILE; c++)
            begin
                dot = '0;
                for (int k = 0; k < TILE; k++)
                    dot = dot + a_tile[r * TILE + k] * b_tile[k * TILE + c];
                c_sum[r * TILE + c] = c_sum[r * TILE + c] + dot;
            end
    endtask

    // Queue the C tile in row-major order and clear the accumulator
    task automatic drain_c_tile();
        result_t entry;
        for (int i = 0; i < AREA; i++)
        begin
            entry.c_value = c_sum[i];
            entry.last    = (i == AREA - 1);
            c_tile_due.push_back(entry);
            c_sum[i] = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AREA; i++)
                c_sum[i] = '0;
            c_tile_due.delete();
            fill_pos      = 0;
            fail_count    = 0;
            expected_left = 0;
            items_taken   = 0;
            results_taken = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (c_tile_due.size() == 0)
                    log_mismatch("unexpected result", '0, result.c_value);
                else
                begin
                    want = c_tile_due.pop_front();
                    if (result.c_value !== want.c_value)
                        log_mismatch("c_value", want.c_value, result.c_value);
                    if (result.last !== want.last)
                        log_mismatch("last", 32'(want.last), 32'(result.last));
                end
                results_taken++;
            end
            if (start && !busy)
            begin
                a_tile[fill_pos] = operands.a_value;
                b_tile[fill_pos] = operands.b_value;
                items_taken++;
                if (fill_pos == AREA - 1)
                begin
                    fill_pos = 0;
                    fold_tile_product();
                    if (operands.final_block)
                        drain_c_tile();
                end
                else
                    fill_pos++;
            end
            expected_left = c_tile_due.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tmm_pkg::*;

    localparam int TILE       = 8;
    localparam int AREA       = TILE * TILE;
    // Tile 0 accumulates without emitting, tile 1 ends with an emit, and a
    // short partial tile follows that must give no result
    localparam int TILES      = 3;
    localparam int TAIL_ITEMS = 6;
    // One tile runs TILE^3 MACs with nothing accepted; allow several
    // times that before calling the run hung
    localparam int IDLE_LIMIT = 8 * (TILE * TILE * TILE + 16);

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    operand_t operands;
    result_t  result;
    logic     result_strobe;

    int fail_count;
    int expected_left;
    int items_taken;
    int results_taken;
    int idle_cycles = 0;

    // 2 ns period: one delay high, one low
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tiled_matrix_multiply_accumulate_top #(
        .TILE (TILE)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operands      (operands),
        .result        (result),
        .result_strobe (result_strobe)
    );

    tmm_checker #(
        .TILE (TILE)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operands      (operands),
        .result        (result),
        .result_strobe (result_strobe),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .items_taken   (items_taken),
        .results_taken (results_taken)
    );

    // The corners of a signed 32-bit word: most negative, most positive,
    // zero, minus one and one. Products of these exercise the wrap.
    function automatic logic [31:0] corner_word(input int unsigned sel);
        case (sel % 5)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Mix full-range words with corners and small signed values, so that
    // some sums stay readable and others wrap hard
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1:    return corner_word($urandom_range(0, 4));
            2:       return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. Returns at the
    // rising edge that accepted it.
    task automatic offer_pair(input operand_t item);
        operands <= item;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Watchdog: count cycles in which neither channel moves anything
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", idle_cycles);
            $display("FAIL tiled_matrix_multiply_accumulate_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int       tile_idx;
        int       pos;
        int       burst_left;
        operand_t item;

        // Hold every input at a known value before the first edge
        rst_n    = 1'b0;
        start    = 1'b0;
        operands = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        for (tile_idx = 0; tile_idx < TILES; tile_idx++)
        begin
            // Drop start and hold off until the previous C tile has fully
            // come out, so the last tile starts on a quiet block
            if (tile_idx == TILES - 1)
            begin
                start <= 1'b0;
                do
                    @(negedge clk);
                while (expected_left != 0);
                @(posedge clk);
            end

            for (pos = 0; pos < ((tile_idx == TILES - 1) ? TAIL_ITEMS : AREA); pos++)
            begin
                if (tile_idx == 0 && pos < 25)
                begin
                    // Directed opening: every pairing of the corner words,
                    // with the final flag raised on the odd pairs, which do not end
                    // the tile, where it must be ignored
                    item.a_value     = corner_word(pos);
                    item.b_value     = corner_word(pos / 5);
                    item.final_block = pos[0];
                end
                else
                begin
                    item.a_value     = pick_word();
                    item.b_value     = pick_word();
                    item.final_block = 1'($urandom_range(0, 1));
                end
                // The first tile only accumulates; later tiles emit
                if (pos == AREA - 1)
                    item.final_block = (tile_idx != 0);

                // Send in bursts; a long burst gives a stretch with no gaps
                if (burst_left == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                end
                burst_left--;
                offer_pair(item);
            end
        end

        // Drain: wait for every queued C result, then a short settling hold
        start <= 1'b0;
        do
            @(negedge clk);
        while (expected_left != 0);
        repeat (20) @(posedge clk);

        $display("Covered %0d operand items: %0d full %0dx%0d tiles and a partial one, %0d C results",
                 items_taken, TILES - 1, TILE, TILE, results_taken);
        $display("Included corner-word products, ignored early final flags, a non-emitting tile");
        if (fail_count == 0 && expected_left == 0)
            $display("PASS tiled_matrix_multiply_accumulate_top");
        else
            $display("FAIL tiled_matrix_multiply_accumulate_top");
        $finish;
    end

endmodule
